// ===== src/eot_pkg.sv =====
package eot_pkg;

    localparam int TABLE_ROWS_DEF = 1024;
    localparam int EOP_COLS       = 10;

    localparam logic [3:0] LAST_WORD_COL = 4'd9;

    localparam logic [2:0] COL_UT1        = 3'd2;
    localparam logic [2:0] COL_LOD        = 3'd3;
    localparam logic [2:0] COL_LAST_BLEND = 3'd7;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic REG_INTERP = 1'b0;
    localparam logic REG_ROWCNT = 1'b1;

    // arcsec -> rad factor in Q48; the product shifted right by 24 gives Q24 radians
    localparam logic signed [31:0] ARCSEC_RAD_K = 32'sd1364629196;

    localparam logic signed [64:0] RND_BLEND   = 65'sd32768;
    localparam logic signed [64:0] RND_RAD     = 65'sd8388608;
    localparam int                 BLEND_SHIFT = 16;
    localparam int                 RAD_SHIFT   = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_A,
        ST_RD_B,
        ST_BLEND_GO,
        ST_BLEND_WAIT,
        ST_CONV_GO,
        ST_CONV_WAIT,
        ST_NEXT,
        ST_TAI,
        ST_DONE
    } t_state;

    typedef enum logic {
        MUL_BLEND,
        MUL_RAD
    } t_mul_mode;

    typedef struct packed {
        logic               go;
        t_mul_mode          mode;
        logic signed [32:0] op_a;
        logic signed [31:0] op_b;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic signed [40:0] value;
    } t_mul_rsp;

endpackage

// ===== src/eot_table.sv =====
module eot_table
    import eot_pkg::*;
#(
    parameter int TABLE_ROWS = TABLE_ROWS_DEF,
    parameter int AW         = $clog2(TABLE_ROWS * EOP_COLS)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [31:0]   i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [31:0]   o_rd_data
);

    localparam int DEPTH = TABLE_ROWS * EOP_COLS;

    logic [31:0] r_mem [0:DEPTH-1];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/eot_mul.sv =====
module eot_mul
    import eot_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic               r_p_valid;
    logic               r_done;
    logic signed [64:0] r_prod;
    t_mul_mode          r_mode;
    logic signed [40:0] r_res;
    logic signed [64:0] w_sum;
    logic signed [64:0] w_shifted;

    always_comb begin
        w_sum     = r_prod + ((r_mode == MUL_BLEND) ? RND_BLEND : RND_RAD);
        w_shifted = (r_mode == MUL_BLEND) ? (w_sum >>> BLEND_SHIFT) : (w_sum >>> RAD_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_p_valid <= i_req.go;
            r_done    <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_prod <= $signed(i_req.op_a) * $signed(i_req.op_b);
            r_mode <= i_req.mode;
        end
        if (r_p_valid) begin
            r_res <= w_shifted[40:0];
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_res;

endmodule

// ===== src/earth_orientation_table_interpolator_unit.sv =====
// Earth orientation table interpolator. Table words are loaded by write beats
// (out-of-range row or column ignored); a query beat scans the day column of
// rows 0..row_count-1 one row per cycle through the single table read port,
// then runs the eight parameter columns one at a time through a shared
// two-stage multiplier (blend by fraction in linear mode, then arcsec-to-radian
// scaling of the angular columns). A query with no matching day scans every row,
// with row_count capped at the table size; in linear mode a match on the last
// row is also a miss. The input is stalled while a query is in progress; one
// finished result may wait in the output register while the next beat is taken.
// Table contents are undefined until written.
module earth_orientation_table_interpolator_unit
    import eot_pkg::*;
#(
    parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [9:0]         i_row_index,
    input  logic [3:0]         i_column_select,
    input  logic signed [31:0] i_word_value,
    input  logic [16:0]        i_query_day,
    input  logic [15:0]        i_query_fraction,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic signed [39:0] o_pole_x,
    output logic signed [39:0] o_pole_y,
    output logic signed [31:0] o_ut1_minus_utc,
    output logic signed [31:0] o_day_length,
    output logic signed [39:0] o_nutation_longitude,
    output logic signed [39:0] o_nutation_obliquity,
    output logic signed [39:0] o_pole_x_rate,
    output logic signed [39:0] o_pole_y_rate,
    output logic signed [31:0] o_tai_minus_utc,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = TABLE_ROWS * EOP_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(TABLE_ROWS + 1);

    // config
    logic        r_interp;
    logic [10:0] r_row_count;
    logic [31:0] w_lim32;
    logic [CW-1:0] w_limit;

    // sequencer
    t_state      r_state;
    t_state      n_state;
    logic [16:0] r_qday;
    logic [15:0] r_frac;
    logic [CW-1:0] r_issue_row;
    logic [AW-1:0] r_issue_addr;
    logic          r_cmp_valid;
    logic [CW-1:0] r_cmp_row;
    logic [AW-1:0] r_cmp_addr;
    logic          r_found;
    logic [2:0]    r_col;
    logic [AW-1:0] r_col_addr;
    logic signed [31:0] r_a;
    logic signed [31:0] r_v;
    logic signed [39:0] r_vals [0:7];
    logic signed [31:0] r_tai;

    // output register
    logic               r_out_valid;
    logic               r_o_found;
    logic signed [39:0] r_ov [0:7];
    logic signed [31:0] r_otai;

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_issue;
    logic          w_match;
    logic          w_last;
    logic          w_angular;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [31:0]   w_rd_data;
    logic          w_wr_en;
    logic [31:0]   w_wr_addr32;
    t_mul_req      w_mul_req;
    t_mul_rsp      w_mul_rsp;

    // APB registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWCNT) ? {21'b0, r_row_count} : {31'b0, r_interp};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp    <= 1'b0;
            r_row_count <= 11'd0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_INTERP: r_interp    <= pwdata[0];
                REG_ROWCNT: r_row_count <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    assign w_lim32 = ({21'b0, r_row_count} > 32'(TABLE_ROWS)) ? 32'(TABLE_ROWS)
                                                               : {21'b0, r_row_count};
    assign w_limit = w_lim32[CW-1:0];

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // table write
    assign w_wr_addr32 = ({22'b0, i_row_index} << 3) + ({22'b0, i_row_index} << 1)
                       + {28'b0, i_column_select};
    assign w_wr_en = w_in_acc && (i_req_type == REQ_WRITE)
                   && ({22'b0, i_row_index} < 32'(TABLE_ROWS))
                   && (i_column_select <= LAST_WORD_COL);

    eot_table #(
        .TABLE_ROWS (TABLE_ROWS),
        .AW         (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr32[AW-1:0]),
        .i_wr_data (i_word_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    eot_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign w_match   = r_cmp_valid && (w_rd_data == {15'b0, r_qday});
    assign w_last    = (({1'b0, r_cmp_row} + (CW+1)'(1)) >= {1'b0, w_limit});
    assign w_angular = !((r_col == COL_UT1) || (r_col == COL_LOD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_rd_en   = 1'b0;
        w_rd_addr = r_col_addr;
        w_issue   = 1'b0;
        w_mul_req = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_req_type == REQ_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_issue   = (r_issue_row < w_limit);
                w_rd_en   = w_issue;
                w_rd_addr = r_issue_addr;
                if (w_match) begin
                    n_state = (r_interp && w_last) ? ST_DONE : ST_RD_A;
                end else if (!w_issue && !r_cmp_valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_RD_A: begin
                w_rd_en = 1'b1;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                if (r_interp) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_col_addr + AW'(EOP_COLS);
                    n_state   = ST_BLEND_GO;
                end else begin
                    n_state = ST_CONV_GO;
                end
            end
            ST_BLEND_GO: begin
                w_mul_req.go   = 1'b1;
                w_mul_req.mode = MUL_BLEND;
                w_mul_req.op_a = {w_rd_data[31], w_rd_data} - {r_a[31], r_a};
                w_mul_req.op_b = {16'b0, r_frac};
                n_state        = ST_BLEND_WAIT;
            end
            ST_BLEND_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = ST_CONV_GO;
                end
            end
            ST_CONV_GO: begin
                if (w_angular) begin
                    w_mul_req.go   = 1'b1;
                    w_mul_req.mode = MUL_RAD;
                    w_mul_req.op_a = {r_v[31], r_v};
                    w_mul_req.op_b = ARCSEC_RAD_K;
                    n_state        = ST_CONV_WAIT;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_CONV_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (r_col == COL_LAST_BLEND) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_col_addr + AW'(1);
                    n_state   = ST_TAI;
                end else begin
                    n_state = ST_RD_A;
                end
            end
            ST_TAI: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_req_type == REQ_QUERY)) begin
                        r_cmp_valid <= 1'b0;
                        r_found     <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_cmp_valid <= w_issue;
                    if (w_match && !(r_interp && w_last)) begin
                        r_found <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_req_type == REQ_QUERY)) begin
                    r_qday       <= i_query_day;
                    r_frac       <= i_query_fraction;
                    r_issue_row  <= '0;
                    r_issue_addr <= '0;
                end
            end
            ST_SCAN: begin
                r_cmp_row  <= r_issue_row;
                r_cmp_addr <= r_issue_addr;
                if (w_issue) begin
                    r_issue_row  <= r_issue_row + CW'(1);
                    r_issue_addr <= r_issue_addr + AW'(EOP_COLS);
                end
                if (w_match) begin
                    r_col      <= '0;
                    r_col_addr <= r_cmp_addr + AW'(1);
                end
            end
            ST_RD_B: begin
                r_a <= w_rd_data;
                r_v <= w_rd_data;
            end
            ST_BLEND_WAIT: begin
                if (w_mul_rsp.done) begin
                    r_v <= r_a + w_mul_rsp.value[31:0];
                end
            end
            ST_CONV_GO: begin
                if (!w_angular) begin
                    r_vals[r_col] <= {{8{r_v[31]}}, r_v};
                end
            end
            ST_CONV_WAIT: begin
                if (w_mul_rsp.done) begin
                    r_vals[r_col] <= w_mul_rsp.value[39:0];
                end
            end
            ST_NEXT: begin
                if (r_col != COL_LAST_BLEND) begin
                    r_col      <= r_col + 3'd1;
                    r_col_addr <= r_col_addr + AW'(1);
                end
            end
            ST_TAI: begin
                r_tai <= w_rd_data;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_o_found <= r_found;
            r_otai    <= r_found ? r_tai : '0;
            for (int k = 0; k < 8; k++) begin
                r_ov[k] <= r_found ? r_vals[k] : '0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_found              = r_o_found;
    assign o_pole_x             = r_ov[0];
    assign o_pole_y             = r_ov[1];
    assign o_ut1_minus_utc      = r_ov[2][31:0];
    assign o_day_length         = r_ov[3][31:0];
    assign o_nutation_longitude = r_ov[4];
    assign o_nutation_obliquity = r_ov[5];
    assign o_pole_x_rate        = r_ov[6];
    assign o_pole_y_rate        = r_ov[7];
    assign o_tai_minus_utc      = r_otai;

`ifndef ASSERT_OFF
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_req_type == REQ_WRITE)) |=> (r_state == ST_IDLE))
        else $error("write beat left the sequencer busy");

    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_req_type == REQ_QUERY)) |=> (r_state == ST_SCAN))
        else $error("query beat did not start a scan");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue_row <= w_limit))
        else $error("scan ran past the row limit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_found) |-> ((r_ov[0] == '0) && (r_ov[4] == '0) && (r_otai == '0)))
        else $error("miss result carries nonzero fields");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_rsp.done |-> ((r_state == ST_BLEND_WAIT) || (r_state == ST_CONV_WAIT)))
        else $error("multiplier result arrived with no one waiting");
`endif

endmodule

// ===== tb/tb_earth_orientation_table_interpolator_unit.sv =====
`timescale 1ns / 1ps

module tb_earth_orientation_table_interpolator_unit;
    import eot_pkg::*;

    localparam int     CLK_PERIOD     = 20;
    localparam int     N_ROWS         = TABLE_ROWS_DEF;
    localparam int     LOAD_ROWS      = 24;
    localparam int     DAY_BASE       = 58000;
    localparam int     IDLE_PCT       = 37;
    localparam int     RANDOM_ITEMS   = 270;
    localparam int     CFG_SETTLE     = 16;
    localparam int     TAIL_CYCLES    = 100;
    localparam int     WATCHDOG_LIMIT = 20000;
    localparam longint ARCSEC_RAD_Q24 = 64'sd1364629196;

    localparam logic [2:0] ADDR_INTERP = {REG_INTERP, 2'b00};
    localparam logic [2:0] ADDR_ROWCNT = {REG_ROWCNT, 2'b00};

    typedef struct packed {
        logic               found;
        logic signed [39:0] pole_x;
        logic signed [39:0] pole_y;
        logic signed [31:0] ut1_minus_utc;
        logic signed [31:0] day_length;
        logic signed [39:0] nutation_longitude;
        logic signed [39:0] nutation_obliquity;
        logic signed [39:0] pole_x_rate;
        logic signed [39:0] pole_y_rate;
        logic signed [31:0] tai_minus_utc;
    } t_eop_result;

    typedef struct packed {
        logic        req;
        logic [9:0]  row;
        logic [3:0]  col;
        logic [31:0] word;
        logic [16:0] day;
        logic [15:0] frac;
        logic        typed_miss;
    } t_eop_beat;

    typedef struct packed {
        logic        lin;
        logic [10:0] rcnt;
        t_eop_beat   beat;
    } t_dir_row;

    localparam int N_DIR = 27;
    localparam t_dir_row DIR_STIM [N_DIR] = '{
        '{1'b0, 11'd0,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'd0, 16'd0, 1'b1}},
        '{1'b0, 11'd0,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'd131071, 16'd65535, 1'b1}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd1, 4'd1,  32'h7FFF_FFFF, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd1, 4'd2,  32'h8000_0000, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd2, 4'd1,  32'h8000_0000, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd2, 4'd2,  32'h7FFF_FFFF, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd1, 4'd9,  32'h7FFF_FFFF, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd2, 4'd4,  32'h8000_0000, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd3, 4'd0,  32'd131071, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd5, 4'd0,  32'd0, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd4, 4'd10, 32'h1234_5678, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_WRITE, 10'd4, 4'd15, 32'hFFFF_FFFF, 17'd0, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'd131071, 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'd0, 16'd65535, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 1), 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 4), 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 7), 16'd0, 1'b0}},
        '{1'b0, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'd7, 16'd0, 1'b1}},
        '{1'b1, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 1), 16'd65535, 1'b0}},
        '{1'b1, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 1), 16'd0, 1'b0}},
        '{1'b1, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 2), 16'd32768, 1'b0}},
        '{1'b1, 11'd8,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 7), 16'd0, 1'b1}},
        '{1'b1, 11'd1,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE), 16'd100, 1'b1}},
        '{1'b0, 11'd2047, '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 20), 16'd0, 1'b0}},
        '{1'b1, 11'd1025, '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 22), 16'd1, 1'b0}},
        '{1'b1, 11'd1024, '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE + 10), 16'd40000, 1'b0}},
        '{1'b1, 11'd0,    '{REQ_QUERY, 10'd0, 4'd0,  32'd0, 17'(DAY_BASE), 16'd0, 1'b1}}
    };

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               i_req_type       = 1'b0;
    logic [9:0]         i_row_index      = '0;
    logic [3:0]         i_column_select  = '0;
    logic signed [31:0] i_word_value     = '0;
    logic [16:0]        i_query_day      = '0;
    logic [15:0]        i_query_fraction = '0;
    logic               i_out_stall      = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [2:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_found;
    logic signed [39:0] o_pole_x;
    logic signed [39:0] o_pole_y;
    logic signed [31:0] o_ut1_minus_utc;
    logic signed [31:0] o_day_length;
    logic signed [39:0] o_nutation_longitude;
    logic signed [39:0] o_nutation_obliquity;
    logic signed [39:0] o_pole_x_rate;
    logic signed [39:0] o_pole_y_rate;
    logic signed [31:0] o_tai_minus_utc;
    logic [31:0]        prdata;
    logic               pready;

    earth_orientation_table_interpolator_unit u_top (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] eop_words [N_ROWS][EOP_COLS];
    logic               lin_mode  = 1'b0;
    logic [10:0]        rows_cfg  = '0;

    t_eop_result pending_eop_results [$];
    t_eop_result due_result;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          idle_pct     = IDLE_PCT;

    function automatic logic signed [39:0] arcsec_to_rad(input longint v);
        return 40'((v * ARCSEC_RAD_Q24 + 64'sd8388608) >>> 24);
    endfunction

    function automatic t_eop_result predict_eop_query(input logic [16:0] day,
                                                      input logic [15:0] frac);
        t_eop_result r;
        longint      v [9];
        longint      a;
        longint      b;
        int          limit;
        int          hit_row;
        r       = '0;
        limit   = (rows_cfg > N_ROWS) ? N_ROWS : int'(rows_cfg);
        hit_row = -1;
        for (int i = 0; i < limit && hit_row < 0; i++) begin
            if (longint'(eop_words[i][0]) == longint'(day)) hit_row = i;
        end
        if (hit_row < 0 || (lin_mode && hit_row + 1 >= limit)) return r;
        for (int j = 0; j < 8; j++) begin
            a = eop_words[hit_row][j + 1];
            if (lin_mode) begin
                b    = eop_words[hit_row + 1][j + 1];
                v[j] = a + (((b - a) * longint'(frac) + 64'sd32768) >>> 16);
            end else begin
                v[j] = a;
            end
        end
        v[8] = eop_words[hit_row][9];
        r.found              = 1'b1;
        r.pole_x             = arcsec_to_rad(v[0]);
        r.pole_y             = arcsec_to_rad(v[1]);
        r.ut1_minus_utc      = v[2][31:0];
        r.day_length         = v[3][31:0];
        r.nutation_longitude = arcsec_to_rad(v[4]);
        r.nutation_obliquity = arcsec_to_rad(v[5]);
        r.pole_x_rate        = arcsec_to_rad(v[6]);
        r.pole_y_rate        = arcsec_to_rad(v[7]);
        r.tai_minus_utc      = v[8][31:0];
        return r;
    endfunction

    task automatic check_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d got %0d", what, want, got);
        end
    endtask

    task automatic send_beat(input t_eop_beat b);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= b.req;
        i_row_index      <= b.row;
        i_column_select  <= b.col;
        i_word_value     <= b.word;
        i_query_day      <= b.day;
        i_query_fraction <= b.frac;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (b.req == REQ_WRITE) begin
            if (b.col < EOP_COLS) eop_words[b.row][b.col] = b.word;
        end else if (b.typed_miss) begin
            pending_eop_results.push_back('0);
        end else begin
            pending_eop_results.push_back(predict_eop_query(b.day, b.frac));
        end
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input logic [2:0] addr, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field(addr == ADDR_INTERP ? "interp_linear" : "row_count", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic lin, input logic [10:0] rcnt);
        i_in_valid <= 1'b0;
        while (pending_eop_results.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        reg_write(ADDR_INTERP, {31'b0, lin});
        reg_write(ADDR_ROWCNT, {21'b0, rcnt});
        reg_read(ADDR_INTERP, {31'b0, lin});
        reg_read(ADDR_ROWCNT, {21'b0, rcnt});
        lin_mode = lin;
        rows_cfg = rcnt;
    endtask

    // result checker and receive-side stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_eop_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result beat with nothing expected");
                end else begin
                    due_result = pending_eop_results.pop_front();
                    check_field("found", due_result.found, o_found);
                    check_field("pole_x", due_result.pole_x, o_pole_x);
                    check_field("pole_y", due_result.pole_y, o_pole_y);
                    check_field("ut1_minus_utc", due_result.ut1_minus_utc, o_ut1_minus_utc);
                    check_field("day_length", due_result.day_length, o_day_length);
                    check_field("nutation_longitude", due_result.nutation_longitude,
                                o_nutation_longitude);
                    check_field("nutation_obliquity", due_result.nutation_obliquity,
                                o_nutation_obliquity);
                    check_field("pole_x_rate", due_result.pole_x_rate, o_pole_x_rate);
                    check_field("pole_y_rate", due_result.pole_y_rate, o_pole_y_rate);
                    check_field("tai_minus_utc", due_result.tai_minus_utc, o_tai_minus_utc);
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_earth_orientation_table_interpolator_unit: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_eop_beat   b;
        int          n_items;
        int          phase;
        int          len;
        int          limit;
        int          pick_rows;
        int          pick;
        logic        lin;
        logic [10:0] rc;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reg_read(ADDR_INTERP, 32'd0);
        reg_read(ADDR_ROWCNT, 32'd0);

        // load the leading rows: consecutive days, random parameters
        for (int r = 0; r < LOAD_ROWS; r++) begin
            for (int c = 0; c < EOP_COLS; c++) begin
                b      = '0;
                b.req  = REQ_WRITE;
                b.row  = 10'(r);
                b.col  = 4'(c);
                b.word = (c == 0) ? 32'(DAY_BASE + r) : 32'($urandom);
                send_beat(b);
            end
        end

        for (int k = 0; k < N_DIR; k++) begin
            if (DIR_STIM[k].lin !== lin_mode || DIR_STIM[k].rcnt !== rows_cfg)
                set_mode(DIR_STIM[k].lin, DIR_STIM[k].rcnt);
            send_beat(DIR_STIM[k].beat);
        end

        n_items = 0;
        phase   = 0;
        while (n_items < RANDOM_ITEMS) begin
            lin  = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (phase == 2) begin
                rc  = 11'($urandom_range(4, 24));
                len = 70;
            end else if (pick < 6) begin
                rc  = 11'd0;
                len = $urandom_range(5, 15);
            end else if (pick < 12) begin
                case ($urandom_range(0, 3))
                    0: rc = 11'd1024;
                    1: rc = 11'd1025;
                    2: rc = 11'd2047;
                    default: rc = 11'($urandom_range(512, 1024));
                endcase
                len = 4;
            end else begin
                rc  = 11'($urandom_range(1, 24));
                len = $urandom_range(20, 50);
            end
            idle_pct = (phase == 2) ? 0 : IDLE_PCT;
            set_mode(lin, rc);
            limit     = (rc > N_ROWS) ? N_ROWS : int'(rc);
            // long scans must stop inside the loaded rows
            pick_rows = (limit > LOAD_ROWS) ? LOAD_ROWS - 1 : limit;
            repeat (len) begin
                b      = '0;
                b.req  = ($urandom_range(0, 99) < 55) ? REQ_QUERY : REQ_WRITE;
                b.row  = 10'($urandom);
                b.col  = 4'($urandom);
                b.word = 32'($urandom);
                b.day  = 17'($urandom);
                b.frac = 16'($urandom);
                pick   = $urandom_range(0, 99);
                if (b.req == REQ_QUERY) begin
                    if (limit > LOAD_ROWS || (limit > 0 && pick < 80))
                        b.day = eop_words[$urandom_range(0, pick_rows - 1)][0][16:0];
                    pick = $urandom_range(0, 99);
                    if (pick < 10) b.frac = 16'd0;
                    else if (pick < 20) b.frac = 16'hFFFF;
                end else begin
                    if (limit > 0 && pick < 70)
                        b.row = 10'($urandom_range(0, (limit > 1023) ? 1023 : limit));
                    b.col = ($urandom_range(0, 99) < 10) ? 4'($urandom_range(10, 15))
                                                         : 4'($urandom_range(0, 9));
                    pick = $urandom_range(0, 99);
                    if (b.col == 0) begin
                        if (pick < 70) b.word = 32'(DAY_BASE + $urandom_range(0, 30));
                        else if (pick < 90) b.word = 32'($urandom_range(0, 131071));
                    end else if (pick < 15) begin
                        case ($urandom_range(0, 3))
                            0: b.word = 32'h7FFF_FFFF;
                            1: b.word = 32'h8000_0000;
                            2: b.word = 32'h0000_0000;
                            default: b.word = 32'hFFFF_FFFF;
                        endcase
                    end
                end
                send_beat(b);
                if (b.req == REQ_QUERY || b.col < EOP_COLS) n_items++;
            end
            phase++;
        end

        idle_pct = IDLE_PCT;
        i_in_valid <= 1'b0;
        while (pending_eop_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_eop_results.size() == 0) begin
            $display("tb_earth_orientation_table_interpolator_unit: PASS");
        end else begin
            $display("tb_earth_orientation_table_interpolator_unit: FAIL");
        end
        $finish;
    end

endmodule
